[hdl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and codes for the indexed sequence store: request opcodes,
// status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int OP_W  = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_WR   = 5'b00100,
		S_WRV  = 5'b01000,
		S_DONE = 5'b10000
	} seq_state_t;

endpackage

[hdl/iss_ram.sv]
// ----------------------------------------------------------------------------
// iss_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iss_ram
	import iss_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/indexed_sequence_store_core.sv]
// ----------------------------------------------------------------------------
// indexed_sequence_store_core
// Ordered sequence of up to DEPTH signed 32-bit values with indexed insert,
// remove and read, built around one RAM and a small shifting sequencer.
// ----------------------------------------------------------------------------
// Usage: present op, position and value with start while busy is low; the
// item is taken on that edge and busy rises until the result has been shown.
// Every item gives exactly one result, shown for a single cycle with done high;
// the receiver must take it then, as the block cannot be stalled. An insert
// moves each entry from the insert position up to the end one slot higher,
// a remove moves each entry above the position one slot lower; each move is a
// RAM read followed by a RAM write through the single RAM port pair. At most
// DEPTH-1 entries are moved; a successful insert then writes the new value,
// and a successful read makes one RAM read. Busy stays high through the result
// cycle, so the next item can be accepted the cycle after done. A bad position
// reports status 1; an insert into a full store reports status 2 (a bad
// position wins). Failed and unknown requests leave the store untouched and
// go straight from accept to the result.
// read_value is nonzero only for a successful read; count is the length after
// the request. There is no clearing pass after reset: only the sequencer registers and the length reset.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core
	import iss_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic signed [VAL_W-1:0] read_value,
	output logic [ST_W-1:0]         status,
	output logic [CNT_W-1:0]        count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	seq_state_t state_q;

	logic [CW-1:0]           fill_q;
	logic [OP_W-1:0]         op_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [ST_W-1:0]         st_q;
	logic                    rsel_q;

	logic                    accept;
	logic [PW-1:0]           pos_ext;
	logic [PW-1:0]           fill_ext;
	logic [ST_W-1:0]         st_new;
	logic [AW-1:0]           nb;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic signed [VAL_W-1:0] ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic signed [VAL_W-1:0] ram_rdata;

	assign accept   = start && (state_q == S_IDLE);
	assign pos_ext  = PW'(position);
	assign fill_ext = PW'(fill_q);

	// check the request against the current length
	always_comb begin
		st_new = ST_OK;
		unique case (op)
			OP_INSERT: begin
				if (pos_ext > fill_ext) begin
					st_new = ST_RANGE;
				end else if (fill_q == CW'(DEPTH)) begin
					st_new = ST_FULL;
				end
			end
			OP_REMOVE, OP_READ: begin
				if (pos_ext >= fill_ext) begin
					st_new = ST_RANGE;
				end
			end
			default: st_new = ST_OK;
		endcase
	end

	// shared index step: walk down for insert, up for remove
	assign nb = (op_q == OP_INSERT) ? (idx_q - AW'(1)) : (idx_q + AW'(1));

	// RAM port control
	always_comb begin
		ram_re    = (state_q == S_RD);
		ram_raddr = (op_q == OP_READ) ? idx_q : nb;
		ram_we    = (state_q == S_WR) || (state_q == S_WRV);
		ram_waddr = (state_q == S_WRV) ? pos_q : idx_q;
		ram_wdata = (state_q == S_WRV) ? val_q : ram_rdata;
	end

	iss_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			pos_q <= pos_ext[AW-1:0];
			val_q <= value;
			st_q  <= st_new;
		end
	end

	// sequencer; fill is updated at accept, so the remove walk compares
	// against the new length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			rsel_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// route read data to the output only for a good read
						rsel_q <= (st_new == ST_OK) && (op == OP_READ);
						if (st_new != ST_OK) begin
							state_q <= S_DONE;
						end else begin
							unique case (op)
								OP_INSERT: begin
									fill_q <= fill_q + CW'(1);
									idx_q  <= fill_q[AW-1:0];
									state_q <= (pos_ext == fill_ext) ? S_WRV : S_RD;
								end
								OP_REMOVE: begin
									fill_q <= fill_q - CW'(1);
									idx_q  <= pos_ext[AW-1:0];
									state_q <= (pos_ext + PW'(1) < fill_ext) ? S_RD : S_DONE;
								end
								OP_READ: begin
									idx_q   <= pos_ext[AW-1:0];
									state_q <= S_RD;
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
				end
				S_RD: begin
					state_q <= (op_q == OP_READ) ? S_DONE : S_WR;
				end
				S_WR: begin
					idx_q <= nb;
					if (op_q == OP_INSERT) begin
						state_q <= (nb == pos_q) ? S_WRV : S_RD;
					end else begin
						state_q <= (CW'(nb) < fill_q) ? S_RD : S_DONE;
					end
				end
				S_WRV: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_DONE);
	assign read_value = rsel_q ? ram_rdata : '0;
	assign status     = st_q;
	assign count      = CNT_W'(fill_q);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("sequencer did not leave idle after accept");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (fill_q == CW'(DEPTH)))
		else $error("full status reported with room left");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (fill_q <= CW'(DEPTH)))
		else $error("length exceeds depth");
`endif

endmodule

[bench/indexed_sequence_store_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_core_checker
// Watches the request and result channels of the sequence store, keeps its
// own copy of the sequence, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core_checker
	import iss_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    done,
	input  logic signed [VAL_W-1:0] read_value,
	input  logic [ST_W-1:0]         status,
	input  logic [CNT_W-1:0]        count,
	output int                      pending,
	output int                      mismatches,
	output int                      checked,
	output int                      range_hits,
	output int                      full_hits
);

	typedef struct {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] rd;
		logic [ST_W-1:0]         st;
		logic [CNT_W-1:0]        cnt;
	} outcome_t;

	outcome_t                outcome_q[$];
	logic signed [VAL_W-1:0] seq_mem [DEPTH];
	int                      seq_len;
	int                      err_n;
	int                      chk_n;
	int                      range_n;
	int                      full_n;

	// Apply one request to the mirrored sequence and return what it must answer.
	function automatic outcome_t apply_request(input logic [OP_W-1:0] req_op,
		input logic [POS_W-1:0] req_pos, input logic signed [VAL_W-1:0] req_val);
		outcome_t o;
		int       p;
		int       i;
		p     = int'(req_pos);
		o.op  = req_op;
		o.pos = req_pos;
		o.rd  = '0;
		o.st  = ST_OK;
		case (req_op)
			OP_INSERT: begin
				if (p > seq_len) begin
					o.st = ST_RANGE;
				end else if (seq_len >= DEPTH) begin
					o.st = ST_FULL;
				end else begin
					for (i = seq_len; i > p; i--)
						seq_mem[i] = seq_mem[i-1];
					seq_mem[p] = req_val;
					seq_len++;
				end
			end
			OP_REMOVE: begin
				if (p >= seq_len) begin
					o.st = ST_RANGE;
				end else begin
					for (i = p; i + 1 < seq_len; i++)
						seq_mem[i] = seq_mem[i+1];
					seq_len--;
				end
			end
			OP_READ: begin
				if (p >= seq_len)
					o.st = ST_RANGE;
				else
					o.rd = seq_mem[p];
			end
			default: begin
			end
		endcase
		o.cnt = CNT_W'(seq_len);
		return o;
	endfunction

	task automatic note_error(input string msg);
		err_n++;
		if (err_n <= 10)
			$display("%0t ERROR %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			outcome_q.delete();
			seq_len = 0;
			err_n   = 0;
			chk_n   = 0;
			range_n = 0;
			full_n  = 0;
		end else begin
			// Retire the result first: a new request cannot be taken in a done cycle.
			if (done) begin
				if (outcome_q.size() == 0) begin
					note_error($sformatf("unexpected result: value %0d status %0d count %0d",
						read_value, status, count));
				end else begin
					want = outcome_q.pop_front();
					chk_n++;
					if (want.st == ST_RANGE)
						range_n++;
					if (want.st == ST_FULL)
						full_n++;
					if (read_value !== want.rd || status !== want.st || count !== want.cnt)
						note_error($sformatf({"op %0d pos %0d: expected value %0d status %0d ",
							"count %0d, got value %0d status %0d count %0d"},
							want.op, want.pos, want.rd, want.st, want.cnt,
							read_value, status, count));
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_request(op, position, value));
		end
		pending    <= outcome_q.size();
		mismatches <= err_n;
		checked    <= chk_n;
		range_hits <= range_n;
		full_hits  <= full_n;
	end

endmodule

[bench/indexed_sequence_store_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_core_tb
// Drives insert, remove, read and unused requests into the sequence store in
// bursts with random gaps: a directed opening over empty, partial and full
// stores, then random phases that fill, churn and drain the sequence. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core_tb;
	import iss_pkg::*;

	localparam int              DEPTH      = 16;
	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
	localparam int              PHASE_LEN  = 120;
	// Allow well past the longest item, which moves DEPTH-1 entries.
	localparam int              TAIL_CYC   = 4 * DEPTH;
	localparam int              TIMEOUT_NS = 10_000_000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [OP_W-1:0]         op;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        count;

	int pending;
	int mismatches;
	int checked;
	int range_hits;
	int full_hits;

	// Stimulus-side bookkeeping: the length the store should have, used only
	// to aim positions at the interesting range, and per-op item counts.
	int est_len;
	int burst_left;
	int op_sent [4];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	indexed_sequence_store_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.position   (position),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.count      (count)
	);

	indexed_sequence_store_core_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.position   (position),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.count      (count),
		.pending    (pending),
		.mismatches (mismatches),
		.checked    (checked),
		.range_hits (range_hits),
		.full_hits  (full_hits)
	);

	// End of a burst: drop start and idle for a while, then pick the next
	// burst length. Inside a burst, start stays high from item to item.
	task automatic idle_between();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			if ($urandom_range(0, 15) == 0)
				repeat ($urandom_range(20, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// Present one item and hold it until the block takes it.
	task automatic issue(input logic [OP_W-1:0] o, input int p,
		input logic [VAL_W-1:0] v);
		op       <= o;
		position <= POS_W'(p);
		value    <= v;
		start    <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		op_sent[o]++;
		case (o)
			OP_INSERT: if (p <= est_len && est_len < DEPTH) est_len++;
			OP_REMOVE: if (p < est_len) est_len--;
			default: begin
			end
		endcase
		idle_between();
	endtask

	// Hold off new items until every expected result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(input int ins_pct, input int rem_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return OP_INSERT;
		if (r < ins_pct + rem_pct)
			return OP_REMOVE;
		if (r < 97)
			return OP_READ;
		return OP_UNUSED;
	endfunction

	// Mostly legal positions, with the ends favored; now and then anything
	// the field can carry.
	function automatic int pick_pos(input logic [OP_W-1:0] o);
		int top_ok;
		top_ok = (o == OP_INSERT) ? est_len : est_len - 1;
		if ($urandom_range(0, 9) < 2 || top_ok < 0)
			return $urandom_range(0, 31);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return top_ok;
			default: return $urandom_range(0, top_ok);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		logic [OP_W-1:0] o;
		int              ph;
		int              n;
		int              ins_w [4];
		int              rem_w [4];

		ins_w = '{60, 35, 15, 35};
		rem_w = '{15, 35, 60, 30};
		est_len    = 0;
		burst_left = $urandom_range(0, 12);
		op_sent    = '{0, 0, 0, 0};

		arst_n   <= 1'b0;
		start    <= 1'b0;
		op       <= OP_READ;
		position <= '0;
		value    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: every position is out of range.
		issue(OP_READ,   0, '0);
		issue(OP_REMOVE, 0, '0);
		issue(OP_INSERT, 1, 32'h1234_5678);
		// Build a short sequence: front inserts, one at the end, one in the middle.
		issue(OP_INSERT, 0, 32'h7fff_ffff);
		issue(OP_INSERT, 0, 32'h8000_0000);
		issue(OP_INSERT, 2, 32'hffff_ffff);
		issue(OP_INSERT, 1, 32'h0000_0000);
		issue(OP_READ,   3, '0);
		issue(OP_READ,   4, '0);
		// Remove from the middle, then the last entry.
		issue(OP_REMOVE, 1, '0);
		issue(OP_REMOVE, 2, '0);
		// Unused opcode and the top of the position field.
		issue(OP_UNUSED, 31, 32'hffff_ffff);
		issue(OP_READ,   31, '0);
		// Fill to capacity, then hit the full store with good and bad positions.
		while (est_len < DEPTH)
			issue(OP_INSERT, est_len, pick_value());
		issue(OP_INSERT, 5, 32'h5a5a_5a5a);
		issue(OP_INSERT, DEPTH + 1, 32'ha5a5_a5a5);
		issue(OP_READ,   DEPTH - 1, '0);
		wait_drained();

		// Random phases: fill, churn, drain, churn. Pause for all results between.
		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < PHASE_LEN; n++) begin
				o = pick_op(ins_w[ph], rem_w[ph]);
				issue(o, pick_pos(o), pick_value());
			end
			wait_drained();
		end

		repeat (TAIL_CYC) @(posedge clk);
		$display("Items: %0d inserts, %0d removes, %0d reads, %0d unused; %0d results checked.",
			op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_READ], op_sent[OP_UNUSED],
			checked);
		$display("Out-of-range requests: %0d, inserts into a full store: %0d.",
			range_hits, full_hits);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
